/* rtl/core/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helper functions of the 3x3 box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  // channel and register widths
  localparam int CH_BITS       = 8;
  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 13;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // beat opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // window geometry, tap index is column * 3 + row
  localparam int WIN_DIM    = 3;
  localparam int WIN_TAPS   = WIN_DIM * WIN_DIM;
  localparam int CENTER_TAP = WIN_TAPS / 2;

  // mean arithmetic: (2*sum + n) * ceil(2^18 / 2n) >> 18
  localparam int SUM_BITS    = 12;
  localparam int CNT_BITS    = 4;
  localparam int NUM_BITS    = SUM_BITS + 1;
  localparam int RECIP_BITS  = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rgb_t;

  // one window column, row 0 oldest
  typedef rgb_t [WIN_DIM-1:0] column_t;
  typedef column_t [WIN_DIM-1:0] window_t;

  typedef struct packed {
    rgb_t older;
    rgb_t recent;
  } row_pair_t;

  typedef struct packed {
    logic op;
    rgb_t px;
  } in_item_t;

  typedef struct packed {
    rgb_t [WIN_TAPS-1:0] pixels;
    logic [WIN_TAPS-1:0] mask;
    logic                frame_end;
  } emit_req_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic               frame_end;
  } blur_t;

  // tap mask from column and row validity
  function automatic logic [WIN_TAPS-1:0] build_mask(input logic [WIN_DIM-1:0] cv,
                                                     input logic [WIN_DIM-1:0] rv);
    logic [WIN_TAPS-1:0] m;
    for (int c = 0; c < WIN_DIM; c++) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        m[c*WIN_DIM+r] = cv[c] & rv[r];
      end
    end
    return m;
  endfunction

  // reciprocal of 2n scaled by 2^18, rounded up
  function automatic logic [RECIP_BITS-1:0] recip_of(input logic [CNT_BITS-1:0] n);
    logic [RECIP_BITS-1:0] r;
    unique case (n)
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      4'd9:    r = 18'd14564;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bb3_stream_if.sv */
// ----------------------------------------------------------------------------
// bb3 stream interfaces
// Valid/ready channels for pixel beats in and blurred beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [bb3_pkg::CH_BITS-1:0] red;
  logic [bb3_pkg::CH_BITS-1:0] green;
  logic [bb3_pkg::CH_BITS-1:0] blue;

  modport source (output valid, output op, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input op, input red, input green, input blue,
                  output ready);
endinterface

interface bb3_blur_if;
  logic                        valid;
  logic                        ready;
  logic [bb3_pkg::CH_BITS-1:0] blur_red;
  logic [bb3_pkg::CH_BITS-1:0] blur_green;
  logic [bb3_pkg::CH_BITS-1:0] blur_blue;
  logic                        frame_end;

  modport source (output valid, output blur_red, output blur_green, output blur_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input blur_red, input blur_green, input blur_blue,
                  input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/box_blur_3x3_edge_aware.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// Edge-aware 3x3 box blur on a raster RGB stream. Each output is the per
// channel mean of the neighbours inside the frame, rounded half up. Output
// (y,x) leaves when pixel (y+1,x+1) arrives; the pixel that ends a row also
// releases that row's last column. After the last pixel of the frame, drain
// beats (op = 1) release the final row one output per beat, the last one
// with frame_end set; pixel beats sent while draining are dropped, as are
// drain beats outside the drain phase. A pixel beat has its row buffer entry
// read when it is taken and written back after that read, then issues each
// result it releases (none to two) to the mean pipeline, which may hold an
// issue back; a drain beat makes its three column reads and then one issue;
// a dropped beat is only taken. No new beat is taken before the last one is
// through. Results leave through the registered stages of the mean pipeline,
// whose last stage holds a finished result while the next beat is accepted.
// The row buffers have no reset and need no clearing pass; configuration
// writes restart the frame position and keep row data.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  bb3_pix_if.sink                           pix_i,
  bb3_blur_if.source                        blur_o
);
  import bb3_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  in_item_t  in_item;
  logic      mem_rd_en, mem_wr_en;
  logic [XW-1:0] mem_rd_addr, mem_wr_addr;
  row_pair_t mem_rd_data, mem_wr_data;
  logic      req_valid, req_ready;
  emit_req_t req;
  blur_t     res;

  // input beat
  assign in_item.op       = pix_i.op;
  assign in_item.px.red   = pix_i.red;
  assign in_item.px.green = pix_i.green;
  assign in_item.px.blue  = pix_i.blue;

  bb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (pix_i.valid),
    .in_ready_o    (pix_i.ready),
    .in_item_i     (in_item),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  bb3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  bb3_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (blur_o.valid),
    .out_ready_i (blur_o.ready),
    .out_o       (res)
  );

  // output beat
  assign blur_o.blur_red   = res.red;
  assign blur_o.blur_green = res.green;
  assign blur_o.blur_blue  = res.blue;
  assign blur_o.frame_end  = res.frame_end;

  // write-back always follows the read of the same pixel
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> $past(mem_rd_en))
    else $error("row buffer write without a preceding read");

  // read and write never collide on one entry
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
    else $error("row buffer read and write hit the same entry");

  // every issued window counts its center pixel
  a_center_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid |-> req.mask[CENTER_TAP])
    else $error("mean request without its center pixel");

endmodule

`default_nettype wire

/* rtl/core/bb3_line_store.sv */
// ----------------------------------------------------------------------------
// bb3_line_store
// The two row buffers, one entry per column, read through a registered port.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_line_store #(
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output bb3_pkg::row_pair_t rd_data_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  bb3_pkg::row_pair_t wr_data_i
);
  import bb3_pkg::*;

  rgb_t older_mem  [DEPTH];
  rgb_t recent_mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i]  <= wr_data_i.older;
      recent_mem[wr_addr_i] <= wr_data_i.recent;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o.older  <= older_mem[rd_addr_i];
      rd_data_o.recent <= recent_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bb3_mean.sv */
// ----------------------------------------------------------------------------
// bb3_mean
// Two-stage elastic pipeline: masked window sums, then rounded division by
// the tap count through a reciprocal multiply. Its last stage is the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_mean (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  bb3_pkg::emit_req_t req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bb3_pkg::blur_t     out_o
);
  import bb3_pkg::*;

  logic [SUM_BITS-1:0] sum_r, sum_g, sum_b;
  logic [CNT_BITS-1:0] n_cnt;

  logic                a_valid_q;
  logic [SUM_BITS-1:0] a_sum_r_q, a_sum_g_q, a_sum_b_q;
  logic [CNT_BITS-1:0] a_n_q;
  logic                a_fe_q;
  logic                b_valid_q;
  logic                a_adv, b_adv;

  function automatic logic [CH_BITS-1:0] round_mean(input logic [SUM_BITS-1:0] sum,
                                                    input logic [CNT_BITS-1:0] n);
    logic [NUM_BITS-1:0]  num;
    logic [PROD_BITS-1:0] prod;
    num  = {sum, 1'b0} + NUM_BITS'(n);
    prod = PROD_BITS'(num) * PROD_BITS'(recip_of(n));
    return prod[RECIP_SHIFT +: CH_BITS];
  endfunction

  // stage handshake
  assign b_adv       = !b_valid_q || out_ready_i;
  assign a_adv       = !a_valid_q || b_adv;
  assign req_ready_o = a_adv;
  assign out_valid_o = b_valid_q;

  // masked sums and tap count
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    n_cnt = '0;
    for (int i = 0; i < WIN_TAPS; i++) begin
      if (req_i.mask[i]) begin
        sum_r = sum_r + SUM_BITS'(req_i.pixels[i].red);
        sum_g = sum_g + SUM_BITS'(req_i.pixels[i].green);
        sum_b = sum_b + SUM_BITS'(req_i.pixels[i].blue);
        n_cnt = n_cnt + CNT_BITS'(1);
      end
    end
    if (n_cnt == '0) begin
      n_cnt = CNT_BITS'(1);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= req_valid_i;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (a_adv && req_valid_i) begin
      a_sum_r_q <= sum_r;
      a_sum_g_q <= sum_g;
      a_sum_b_q <= sum_b;
      a_n_q     <= n_cnt;
      a_fe_q    <= req_i.frame_end;
    end
    if (b_adv && a_valid_q) begin
      out_o.red       <= round_mean(a_sum_r_q, a_n_q);
      out_o.green     <= round_mean(a_sum_g_q, a_n_q);
      out_o.blue      <= round_mean(a_sum_b_q, a_n_q);
      out_o.frame_end <= a_fe_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bb3_ctrl.sv */
// ----------------------------------------------------------------------------
// bb3_ctrl
// Frame sequencer: raster counters, row buffer read/write-back, the 3x3
// column window and the issue of up to two mean requests per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_ctrl #(
  parameter  int MAX_WIDTH  = 1024,
  parameter  int MAX_HEIGHT = 4096,
  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bb3_pkg::in_item_t                  in_item_i,
  output logic                               mem_rd_en_o,
  output logic [XW-1:0]                      mem_rd_addr_o,
  input  bb3_pkg::row_pair_t                 mem_rd_data_i,
  output logic                               mem_wr_en_o,
  output logic [XW-1:0]                      mem_wr_addr_o,
  output bb3_pkg::row_pair_t                 mem_wr_data_o,
  output logic                               req_valid_o,
  input  logic                               req_ready_i,
  output bb3_pkg::emit_req_t                 req_o
);
  import bb3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PIX  = 3'd1;
  localparam logic [2:0] ST_DR1  = 3'd2;
  localparam logic [2:0] ST_DR2  = 3'd3;
  localparam logic [2:0] ST_DR3  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [FW_BITS-1:0]   fw_q, fw_d;
  logic [FH_BITS-1:0]   fh_q, fh_d;
  logic [XW-1:0]        x_q, x_d;
  logic [YW-1:0]        y_q, y_d;
  logic [XW-1:0]        dc_q, dc_d;
  logic                 draining_q, draining_d;
  logic                 need_a_q, need_a_d;
  logic                 need_b_q, need_b_d;

  rgb_t                 pix_q;
  window_t              win_q;
  logic [WIN_TAPS-1:0]  mask_a_q, mask_b_q, mask_a_d, mask_b_d;
  logic                 fe_q, fe_d;
  logic                 load_masks;

  logic [WW-1:0]        uw, x_next1, dc_next1;
  logic [HW-1:0]        uh, y_next1;
  logic                 x_last, y_last, dc_last;
  logic [XW-1:0]        dc_prev, dc_after;
  logic                 in_fire, take_pix, take_drain, shift_en;
  column_t              new_col;
  logic [WIN_DIM-1:0]   cv_a, cv_b, rv;
  rgb_t [WIN_TAPS-1:0]  px_a, px_b;

  // frame size in use, clamped to 1..max
  always_comb begin
    if (fw_q == '0) begin
      uw = WW'(1);
    end else if (int'(fw_q) > MAX_WIDTH) begin
      uw = WW'(MAX_WIDTH);
    end else begin
      uw = WW'(fw_q);
    end
    if (fh_q == '0) begin
      uh = HW'(1);
    end else if (int'(fh_q) > MAX_HEIGHT) begin
      uh = HW'(MAX_HEIGHT);
    end else begin
      uh = HW'(fh_q);
    end
  end

  // position compares
  assign x_next1  = WW'(x_q) + WW'(1);
  assign y_next1  = HW'(y_q) + HW'(1);
  assign dc_next1 = WW'(dc_q) + WW'(1);
  assign x_last   = x_next1 >= uw;
  assign y_last   = y_next1 >= uh;
  assign dc_last  = dc_next1 >= uw;
  assign dc_prev  = (dc_q == '0) ? '0 : dc_q - XW'(1);
  assign dc_after = (dc_next1 >= WW'(MAX_WIDTH)) ? '0 : dc_next1[XW-1:0];

  // input handshake
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign take_pix   = in_fire && (in_item_i.op == OP_PIXEL) && !draining_q;
  assign take_drain = in_fire && (in_item_i.op == OP_DRAIN) && draining_q;

  // row buffer access
  always_comb begin
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = x_q;
    unique case (state_q)
      ST_IDLE: begin
        mem_rd_en_o   = take_pix || take_drain;
        mem_rd_addr_o = take_drain ? dc_prev : x_q;
      end
      ST_DR1: begin
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = dc_q;
      end
      ST_DR2: begin
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = dc_after;
      end
      default: begin
        mem_rd_en_o   = 1'b0;
      end
    endcase
  end

  // write back: recent row moves to older, new pixel becomes recent
  assign mem_wr_en_o          = (state_q == ST_PIX);
  assign mem_wr_addr_o        = x_q;
  assign mem_wr_data_o.older  = mem_rd_data_i.recent;
  assign mem_wr_data_o.recent = pix_q;

  // column entering the window
  assign shift_en   = (state_q == ST_PIX) || (state_q == ST_DR1) ||
                      (state_q == ST_DR2) || (state_q == ST_DR3);
  assign new_col[0] = mem_rd_data_i.older;
  assign new_col[1] = mem_rd_data_i.recent;
  assign new_col[2] = (state_q == ST_PIX) ? pix_q : '0;

  // request payloads: full window, or the row-end window with the right column out
  always_comb begin
    for (int r = 0; r < WIN_DIM; r++) begin
      px_a[r]             = win_q[0][r];
      px_a[WIN_DIM+r]     = win_q[1][r];
      px_a[2*WIN_DIM+r]   = win_q[2][r];
      px_b[r]             = win_q[1][r];
      px_b[WIN_DIM+r]     = win_q[2][r];
      px_b[2*WIN_DIM+r]   = win_q[2][r];
    end
  end

  assign req_valid_o     = (state_q == ST_EMIT);
  assign req_o.pixels    = need_a_q ? px_a : px_b;
  assign req_o.mask      = need_a_q ? mask_a_q : mask_b_q;
  assign req_o.frame_end = need_a_q && fe_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    fw_d       = fw_q;
    fh_d       = fh_q;
    x_d        = x_q;
    y_d        = y_q;
    dc_d       = dc_q;
    draining_d = draining_q;
    need_a_d   = need_a_q;
    need_b_d   = need_b_q;
    fe_d       = fe_q;
    load_masks = 1'b0;
    cv_a       = '0;
    cv_b       = '0;
    rv         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (take_pix) begin
          state_d = ST_PIX;
        end else if (take_drain) begin
          state_d = ST_DR1;
        end
      end
      ST_PIX: begin
        load_masks = 1'b1;
        rv         = {1'b1, 1'b1, (y_q > YW'(1))};
        cv_a       = {1'b1, 1'b1, (x_q > XW'(1))};
        cv_b       = {1'b0, 1'b1, (x_q != '0)};
        need_a_d   = (y_q != '0) && (x_q != '0);
        need_b_d   = (y_q != '0) && x_last;
        fe_d       = 1'b0;
        state_d    = (need_a_d || need_b_d) ? ST_EMIT : ST_IDLE;
        if (x_last) begin
          x_d = '0;
          if (y_last) begin
            y_d        = '0;
            dc_d       = '0;
            draining_d = 1'b1;
          end else begin
            y_d = y_next1[YW-1:0];
          end
        end else begin
          x_d = x_next1[XW-1:0];
        end
      end
      ST_DR1: begin
        state_d = ST_DR2;
      end
      ST_DR2: begin
        state_d = ST_DR3;
      end
      ST_DR3: begin
        load_masks = 1'b1;
        rv         = {1'b0, 1'b1, (uh > HW'(1))};
        cv_a       = {!dc_last, 1'b1, (dc_q != '0)};
        need_a_d   = 1'b1;
        need_b_d   = 1'b0;
        fe_d       = dc_last;
        state_d    = ST_EMIT;
        if (dc_last) begin
          x_d        = '0;
          y_d        = '0;
          dc_d       = '0;
          draining_d = 1'b0;
        end else begin
          dc_d = dc_next1[XW-1:0];
        end
      end
      ST_EMIT: begin
        if (req_ready_i) begin
          if (need_a_q) begin
            need_a_d = 1'b0;
            if (!need_b_q) begin
              state_d = ST_IDLE;
            end
          end else begin
            need_b_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write restarts the frame position
    if (cfg_we_i) begin
      x_d        = '0;
      y_d        = '0;
      dc_d       = '0;
      draining_d = 1'b0;
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_d = cfg_data_i[FW_BITS-1:0];
        CFG_FRAME_HEIGHT: fh_d = cfg_data_i[FH_BITS-1:0];
      endcase
    end
  end

  assign mask_a_d = build_mask(cv_a, rv);
  assign mask_b_d = build_mask(cv_b, rv);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fw_q       <= FW_RESET;
      fh_q       <= FH_RESET;
      x_q        <= '0;
      y_q        <= '0;
      dc_q       <= '0;
      draining_q <= 1'b0;
      need_a_q   <= 1'b0;
      need_b_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      fw_q       <= fw_d;
      fh_q       <= fh_d;
      x_q        <= x_d;
      y_q        <= y_d;
      dc_q       <= dc_d;
      draining_q <= draining_d;
      need_a_q   <= need_a_d;
      need_b_q   <= need_b_d;
    end
  end

  // pixel, window and mask payloads
  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      pix_q <= in_item_i.px;
    end
    if (shift_en) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= new_col;
    end
    if (load_masks) begin
      mask_a_q <= mask_a_d;
      mask_b_q <= mask_b_d;
      fe_q     <= fe_d;
    end
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Raster frames of random and corner-case RGB pixels, with drain beats, stray
// beats and broken frames, go through box_blur_3x3_edge_aware while both
// sides idle at random. A behavioral copy of the window and the row stores
// predicts every blurred beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import bb3_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int RANDOM_BEATS  = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_GAP       = 6;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  bb3_pix_if  pix ();
  bb3_blur_if blur ();

  box_blur_3x3_edge_aware #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .blur_o    (blur)
  );

  always #5 clk_i = ~clk_i;

  // blur state: row stores, window [column][row], column 2 and row 2 newest
  rgb_t               older_row [MAX_W] = '{default: '0};
  rgb_t               recent_row [MAX_W] = '{default: '0};
  rgb_t               win [3][3] = '{default: '0};
  int unsigned        row_pos = 0;
  int unsigned        col_pos = 0;
  int unsigned        drain_pos = 0;
  bit                 draining = 1'b0;
  logic [FW_BITS-1:0] width_reg = FW_RESET;
  logic [FH_BITS-1:0] height_reg = FH_RESET;

  blur_t    means_due [$];
  in_item_t beats_pending [$];

  bit          src_steady = 1'b0;
  bit          snk_steady = 1'b0;
  int unsigned source_hold, sink_hold, stall;
  in_item_t    taken, next_beat;
  blur_t       want;

  int unsigned pixel_beats = 0, drain_beats = 0, dropped_beats = 0;
  int unsigned checked = 0, frames_closed = 0, cfg_writes = 0, random_beats = 0;
  int unsigned mismatches = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  function automatic void restart_position();
    row_pos   = 0;
    col_pos   = 0;
    drain_pos = 0;
    draining  = 1'b0;
  endfunction

  // half-up rounded mean
  function automatic logic [CH_BITS-1:0] round_mean(int unsigned s, int unsigned n);
    int unsigned q;
    q = (2 * s + n) / (2 * n);
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  // mean over the taps inside the frame, queued as the next blurred beat
  function automatic void emit_mean(rgb_t taps [3][3], logic [2:0] col_ok,
                                    logic [2:0] row_ok, logic last);
    int unsigned sr, sg, sb, n;
    blur_t m;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_ok[c] && row_ok[r]) begin
          sr += taps[c][r].red;
          sg += taps[c][r].green;
          sb += taps[c][r].blue;
          n++;
        end
      end
    end
    if (n == 0) n = 1;
    m.red       = round_mean(sr, n);
    m.green     = round_mean(sg, n);
    m.blue      = round_mean(sb, n);
    m.frame_end = last;
    means_due.push_back(m);
  endfunction

  // one accepted beat: move the window and queue the means it releases
  function automatic void advance_window(in_item_t beat);
    int unsigned w, h, x, y, xi, c, idx;
    rgb_t taps [3][3];
    w = active_width();
    h = active_height();
    if (beat.op == OP_DRAIN) begin
      if (!draining) return;
      c = drain_pos;
      for (int k = 0; k < 3; k++) begin
        idx = (c + k + MAX_W - 1) % MAX_W;
        taps[k][0] = older_row[idx];
        taps[k][1] = recent_row[idx];
        taps[k][2] = '0;
      end
      emit_mean(taps, {c + 1 < w, 1'b1, c >= 1}, {1'b0, 1'b1, h >= 2}, c + 1 >= w);
      if (c + 1 >= w) restart_position();
      else drain_pos = c + 1;
      return;
    end
    if (draining) return;

    x  = col_pos;
    y  = row_pos;
    xi = x % MAX_W;
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = older_row[xi];
    win[2][1] = recent_row[xi];
    win[2][2] = beat.px;
    older_row[xi]  = recent_row[xi];
    recent_row[xi] = beat.px;

    if (y >= 1) begin
      if (x >= 1) emit_mean(win, {2'b11, x >= 2}, {2'b11, y >= 2}, 1'b0);
      // row end also releases the last column
      if (x + 1 >= w) begin
        taps[0] = win[1];
        taps[1] = win[2];
        taps[2] = win[2];
        emit_mean(taps, {1'b0, 1'b1, x >= 1}, {2'b11, y >= 2}, 1'b0);
      end
    end

    if (x + 1 >= w) begin
      if (y + 1 >= h) begin
        restart_position();
        draining = 1'b1;
      end else begin
        col_pos = 0;
        row_pos = y + 1;
      end
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic rgb_t rand_px();
    rgb_t p;
    p.red   = 8'($urandom_range(0, 255));
    p.green = 8'($urandom_range(0, 255));
    p.blue  = 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic void push_beat(logic op, rgb_t px);
    in_item_t b;
    b.op = op;
    b.px = px;
    beats_pending.push_back(b);
  endfunction

  // frame at the current size, cut short when counts fall below the full frame
  function automatic void push_frame(int unsigned n_pix, int unsigned n_drain, bit noisy);
    int unsigned w;
    w = active_width();
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) push_beat(OP_DRAIN, rand_px());
      push_beat(OP_PIXEL, rand_px());
    end
    for (int unsigned i = 0; i < n_drain; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) push_beat(OP_PIXEL, rand_px());
      push_beat(OP_DRAIN, rand_px());
    end
    if (noisy && n_drain == w && $urandom_range(0, 3) == 0) push_beat(OP_DRAIN, rand_px());
  endfunction

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_reg = data[FW_BITS-1:0];
    else if (idx == CFG_FRAME_HEIGHT) height_reg = data;
    restart_position();
    cfg_writes++;
  endtask

  // wait for all beats out and all means back, then let the pipeline empty
  task automatic settle();
    while (beats_pending.size() != 0 || pix.valid || means_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input beat driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid   <= 1'b0;
      pix.op      <= OP_PIXEL;
      pix.red     <= '0;
      pix.green   <= '0;
      pix.blue    <= '0;
      source_hold <= 0;
    end else begin
      if (pix.valid && pix.ready) begin
        taken.op       = pix.op;
        taken.px.red   = pix.red;
        taken.px.green = pix.green;
        taken.px.blue  = pix.blue;
        if (taken.op == OP_DRAIN) drain_beats++;
        else pixel_beats++;
        if ((taken.op == OP_DRAIN) != draining) dropped_beats++;
        advance_window(taken);
      end
      if (!pix.valid || pix.ready) begin
        if (source_hold != 0) begin
          pix.valid   <= 1'b0;
          source_hold <= source_hold - 1;
        end else if (beats_pending.size() != 0) begin
          next_beat = beats_pending.pop_front();
          pix.valid   <= 1'b1;
          pix.op      <= next_beat.op;
          pix.red     <= next_beat.px.red;
          pix.green   <= next_beat.px.green;
          pix.blue    <= next_beat.px.blue;
          source_hold <= src_steady ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // blurred beat monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blur.ready <= 1'b0;
      sink_hold  <= 0;
    end else if (blur.valid && blur.ready) begin
      if (means_due.size() == 0) begin
        $error("blurred beat with nothing pending: red %0d green %0d blue %0d frame_end %0b",
               blur.blur_red, blur.blur_green, blur.blur_blue, blur.frame_end);
        mismatches++;
      end else begin
        want = means_due.pop_front();
        if (blur.blur_red !== want.red) begin
          $error("blur_red: expected %0d, got %0d", want.red, blur.blur_red);
          mismatches++;
        end
        if (blur.blur_green !== want.green) begin
          $error("blur_green: expected %0d, got %0d", want.green, blur.blur_green);
          mismatches++;
        end
        if (blur.blur_blue !== want.blue) begin
          $error("blur_blue: expected %0d, got %0d", want.blue, blur.blur_blue);
          mismatches++;
        end
        if (blur.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, blur.frame_end);
          mismatches++;
        end
        checked++;
        if (want.frame_end) frames_closed++;
      end
      stall = snk_steady ? 0 : $urandom_range(0, MAX_GAP);
      sink_hold  <= stall;
      blur.ready <= (stall == 0);
    end else if (!blur.ready) begin
      if (sink_hold <= 1) begin
        blur.ready <= 1'b1;
        sink_hold  <= 0;
      end else begin
        sink_hold <= sink_hold - 1;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned w, h, n_pix, n_drain, kind;
    bit need_cfg;
    rgb_t corner_px [6] = '{
      rgb_t'{8'hFF, 8'h00, 8'hFF}, rgb_t'{8'h00, 8'hFF, 8'h00}, rgb_t'{8'hFF, 8'hFF, 8'hFF},
      rgb_t'{8'h00, 8'h00, 8'h00}, rgb_t'{8'h80, 8'h7F, 8'h01}, rgb_t'{8'hFE, 8'h01, 8'h80}
    };

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_FRAME_WIDTH;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size: row 0 and the start of row 1
    push_frame(active_width() + 2, 0, 1'b0);
    settle();

    // stray drain with no frame in progress
    push_beat(OP_DRAIN, '1);
    settle();

    // zero sizes count as a 1x1 frame
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, '0);
    push_beat(OP_PIXEL, rgb_t'{8'hFF, 8'h80, 8'h00});
    push_beat(OP_PIXEL, '1);  // dropped while draining
    push_beat(OP_DRAIN, '0);
    push_beat(OP_DRAIN, '1);  // dropped, frame already closed
    settle();

    // 3x2 frame of extreme values, upper width bits ignored
    write_reg(CFG_FRAME_WIDTH, 13'h1803);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    foreach (corner_px[i]) push_beat(OP_PIXEL, corner_px[i]);
    repeat (3) push_beat(OP_DRAIN, '0);
    settle();

    // single column frame
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    push_beat(OP_PIXEL, '1);
    push_beat(OP_PIXEL, '0);
    push_beat(OP_PIXEL, rgb_t'{8'h01, 8'hFE, 8'h55});
    push_beat(OP_DRAIN, '1);
    settle();

    // saturated width: full row 0, start of row 1, then cut off
    write_reg(CFG_FRAME_WIDTH, 13'd2047);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    push_frame(MAX_W + 2, 0, 1'b1);
    settle();

    // random frames, some broken off in the pixel or the drain phase
    need_cfg = 1'b1;
    while (random_beats < RANDOM_BEATS) begin
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      if (need_cfg || $urandom_range(0, 3) != 0) begin
        w = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        h = $urandom_range(1, 6);
        if ($urandom_range(0, 11) == 0) w = 0;
        if ($urandom_range(0, 11) == 0) h = 0;
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_FRAME_WIDTH, 13'(w) | (13'($urandom_range(0, 3)) << FW_BITS));
          write_reg(CFG_FRAME_HEIGHT, 13'(h));
        end else begin
          write_reg(CFG_FRAME_HEIGHT, 13'(h));
          write_reg(CFG_FRAME_WIDTH, 13'(w) | (13'($urandom_range(0, 3)) << FW_BITS));
        end
      end
      w        = active_width();
      h        = active_height();
      n_pix    = w * h;
      n_drain  = w;
      need_cfg = 1'b0;
      kind     = $urandom_range(0, 9);
      if (kind == 0) begin
        n_pix    = $urandom_range(0, w * h - 1);
        n_drain  = 0;
        need_cfg = 1'b1;
      end else if (kind == 1) begin
        n_drain  = $urandom_range(0, w - 1);
        need_cfg = 1'b1;
      end
      push_frame(n_pix, n_drain, 1'b1);
      random_beats += n_pix + n_drain;
      settle();
    end

    $display("covered %0d pixel and %0d drain beats (%0d dropped), %0d register writes",
             pixel_beats, drain_beats, dropped_beats, cfg_writes);
    $display("checked %0d blurred beats over %0d closed frames", checked, frames_closed);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
